// ----- src/crs_pkg.sv -----
package crs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int PHASE_BITS_DEF   = 5;
    localparam int RATE_WIDTH       = 6;
    localparam int DIV_STEPS        = 8;

    typedef struct packed {
        logic load;
        logic skip;
        logic finish;
        logic mul1;
        logic mul2;
        logic dload;
        logic div;
        logic emit;
        logic copy;
    } cmd_t;

    typedef struct packed {
        logic pos_due;
        logic full;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- src/cubic_lagrange_resampler.sv -----
// Channel   Signals                              Direction  Transaction when
// input     in_valid in_stall sample_in          in         in_valid && !in_stall
//           buffer_start
// output    out_valid out_stall sample_out       out        out_valid && !out_stall
//           run_last
// config    cfg_valid cfg_ready cfg_data         in         cfg_valid && cfg_ready
//
// Each result is computed by the two multiply stages and the 8-bit-per-cycle divide-by-6
// unit. An input transaction first checks the position, then produces one result per
// due position and skips each position passed over while the window fills; the input
// stalls until that is done. A buffer start loads the sample and copies it out as last.
// Reset is asynchronous, active low; no clearing pass is needed.
// The output register lets the next result's arithmetic run while one waits on
// out_stall; the sequencer only holds before writing it.
module cubic_lagrange_resampler #(
    parameter int SAMPLE_WIDTH = crs_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_BITS   = crs_pkg::PHASE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                                  buffer_start,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output logic                                  run_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic signed [crs_pkg::RATE_WIDTH-1:0] cfg_data
);
    import crs_pkg::*;

    cmd_t    cmd;
    status_t status;

    crs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .buffer_start (buffer_start),
        .status       (status),
        .cmd          (cmd)
    );

    crs_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_BITS   (PHASE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_in    (sample_in),
        .buffer_start (buffer_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .run_last     (run_last)
    );

endmodule

// ----- src/crs_datapath.sv -----
module crs_datapath #(
    parameter int SAMPLE_WIDTH = crs_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_BITS   = crs_pkg::PHASE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  crs_pkg::cmd_t                           cmd,
    output crs_pkg::status_t                        status,
    input  logic signed [SAMPLE_WIDTH-1:0]          sample_in,
    input  logic                                    buffer_start,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic signed [crs_pkg::RATE_WIDTH-1:0]   cfg_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]          sample_out,
    output logic                                    run_last
);
    import crs_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PB    = PHASE_BITS;
    localparam int ONE   = 1 << PB;
    localparam int FW    = PB + 2;
    localparam int MW    = SW + FW;
    localparam int QW    = 2 * FW;
    localparam int AW    = SW + PB + 3;
    localparam int BW    = 2 * PB + 3;
    localparam int PW    = AW + BW;
    localparam int DCYC  = (PW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DW    = DCYC * DIV_STEPS;
    localparam int CNTW  = $clog2(DCYC);
    localparam int POSW  = PB + 2;
    localparam int RW    = (PB + 3 > RATE_WIDTH + 1) ? PB + 3 : RATE_WIDTH + 1;
    localparam int SHIFT = 3 * PB;

    localparam logic [POSW-1:0]        POS_ONE  = POSW'(ONE);
    localparam logic [POSW-1:0]        POS_TWO  = POSW'(2 * ONE);
    localparam logic signed [FW-1:0]   F_ONE    = FW'(ONE);
    localparam logic signed [RW-1:0]   RATE_LO  = -RW'(ONE);
    localparam logic signed [RW-1:0]   RATE_HI  = RW'(ONE - 1);
    localparam logic signed [RW-1:0]   RATE_ONE = RW'(ONE);
    localparam logic signed [PW-1:0]   SMAX     = PW'((1 << (SW - 1)) - 1);
    localparam logic signed [PW-1:0]   SMIN     = -SMAX - PW'(1);
    localparam logic [CNTW-1:0]        CNT_LAST = CNTW'(DCYC - 1);

    logic signed [SW-1:0]     win_reg [4];
    logic [2:0]               fill_reg;
    logic [POSW-1:0]          pos_reg;
    logic signed [RATE_WIDTH-1:0] rate_reg;

    logic signed [AW-1:0]     ac_reg, ao_reg;
    logic signed [BW-1:0]     bc_reg, bo_reg;
    logic signed [PW-1:0]     c_reg, o_reg, c2_reg;
    logic [DW-1:0]            div_reg;
    logic [2:0]               rem_reg;
    logic                     neg_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic                     last_reg;

    logic                     out_valid_reg;
    logic signed [SW-1:0]     sample_reg;
    logic                     run_last_reg;

    logic signed [RW-1:0]     rate_ext, rate_c, adv_w;
    logic [POSW-1:0]          adv, pos_adv;
    logic signed [FW-1:0]     t, xm, xp, xmm;
    logic signed [MW-1:0]     pc1, pc2, po1, po2;
    logic signed [QW-1:0]     pbc, pbo;
    logic signed [AW-1:0]     ac_next, ao_next;
    logic signed [PW-1:0]     c_next, o_next, c2_next;
    logic [PW-1:0]            mag;
    logic [DW-1:0]            div_next;
    logic [2:0]               rem_next;
    logic signed [PW-1:0]     quot, o6, vsum, vshift;
    logic signed [SW-1:0]     vsat;
    logic                     out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rate_ext = RW'(rate_reg);
        if (rate_ext < RATE_LO)
            rate_c = RATE_LO;
        else if (rate_ext > RATE_HI)
            rate_c = RATE_HI;
        else
            rate_c = rate_ext;
        adv_w   = RATE_ONE - rate_c;
        adv     = adv_w[POSW-1:0];
        pos_adv = pos_reg + adv;
    end

    // phase factors, scaled by 2^PB
    always_comb
    begin
        t   = $signed({2'b00, pos_reg[PB-1:0]});
        xm  = t - F_ONE;
        xp  = t + F_ONE;
        xmm = xm - F_ONE;
        pc1 = MW'(xm) * MW'(win_reg[1]);
        pc2 = MW'(t) * MW'(win_reg[2]);
        po1 = MW'(xp) * MW'(win_reg[3]);
        po2 = MW'(xmm) * MW'(win_reg[0]);
        pbc = QW'(xp) * QW'(xmm);
        pbo = QW'(t) * QW'(xm);
        ac_next = AW'(pc1) - AW'(pc2);
        ao_next = AW'(po1) - AW'(po2);
        c_next  = PW'(ac_reg) * PW'(bc_reg);
        o_next  = PW'(ao_reg) * PW'(bo_reg);
    end

    // truncating /2 and magnitude for the /6 unit
    always_comb
    begin
        c2_next = (c_reg + $signed({{(PW-1){1'b0}}, c_reg[PW-1]})) >>> 1;
        mag     = o_reg[PW-1] ? PW'(-o_reg) : o_reg;
    end

    // restoring divide by 6, DIV_STEPS quotient bits per cycle
    always_comb
    begin
        logic [3:0] r4;
        div_next = div_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r4       = {rem_next, div_next[DW-1]};
            div_next = {div_next[DW-2:0], 1'b0};
            if (r4 >= 4'd6)
            begin
                r4          = r4 - 4'd6;
                div_next[0] = 1'b1;
            end
            rem_next = r4[2:0];
        end
    end

    always_comb
    begin
        quot   = $signed(div_reg[PW-1:0]);
        o6     = neg_reg ? -quot : quot;
        vsum   = c2_reg + o6;
        vshift = vsum >>> SHIFT;
        if (vshift > SMAX)
            vsat = SMAX[SW-1:0];
        else if (vshift < SMIN)
            vsat = SMIN[SW-1:0];
        else
            vsat = vshift[SW-1:0];
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.pos_due  = pos_reg < POS_ONE;
        status.full     = fill_reg == 3'd4;
        status.div_done = cnt_reg == CNT_LAST;
        status.out_free = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 3'd0;
            pos_reg       <= POS_ONE;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                rate_reg <= cfg_data;
            if (cmd.load)
            begin
                if (buffer_start)
                begin
                    fill_reg <= 3'd1;
                    pos_reg  <= POS_TWO;
                end
                else if (fill_reg != 3'd4)
                    fill_reg <= fill_reg + 3'd1;
            end
            if (cmd.skip || cmd.mul1)
                pos_reg <= pos_adv;
            if (cmd.finish)
                pos_reg <= pos_reg - POS_ONE;
            if (cmd.emit || cmd.copy)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (buffer_start)
            begin
                win_reg[0] <= '0;
                win_reg[1] <= '0;
                win_reg[2] <= '0;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
            end
            win_reg[3] <= sample_in;
        end
        if (cmd.mul1)
        begin
            ac_reg   <= ac_next;
            ao_reg   <= ao_next;
            bc_reg   <= BW'(pbc);
            bo_reg   <= BW'(pbo);
            last_reg <= pos_adv >= POS_ONE;
        end
        if (cmd.mul2)
        begin
            c_reg <= c_next;
            o_reg <= o_next;
        end
        if (cmd.dload)
        begin
            c2_reg  <= c2_next;
            div_reg <= DW'(mag);
            rem_reg <= 3'd0;
            neg_reg <= o_reg[PW-1];
            cnt_reg <= '0;
        end
        if (cmd.div)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNTW'(1);
        end
        if (cmd.emit)
        begin
            sample_reg   <= vsat;
            run_last_reg <= last_reg;
        end
        else if (cmd.copy)
        begin
            sample_reg   <= win_reg[3];
            run_last_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign run_last   = run_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.copy) |-> out_free)
        else $error("result written while output register held");

    a_mul_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul1 |-> (status.pos_due && status.full))
        else $error("interpolation started off a due position");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POSW'(3 * ONE))
        else $error("position out of range");

    a_copy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy |=> (out_valid && run_last))
        else $error("copied sample not presented as last");

endmodule

// ----- src/crs_ctrl.sv -----
module crs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             buffer_start,
    input  crs_pkg::status_t status,
    output crs_pkg::cmd_t    cmd
);
    import crs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_DLOAD,
        S_DIV,
        S_EMIT,
        S_COPY
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = buffer_start ? S_COPY : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.pos_due)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.full)
                    state_next = S_MUL1;
                else
                    cmd.skip = 1'b1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.dload  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (status.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_COPY:
            begin
                if (status.out_free)
                begin
                    cmd.copy   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_COPY || state_reg == S_CHECK))
        else $error("load did not start a run");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_done) |=> state_reg == S_EMIT)
        else $error("divide finished without emit");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.skip, cmd.finish, cmd.mul1, cmd.mul2,
                  cmd.dload, cmd.div, cmd.emit, cmd.copy}))
        else $error("more than one command at once");

endmodule

// ----- verif/tb_cubic_lagrange_resampler.sv -----
module tb_cubic_lagrange_resampler;

    import crs_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int PB = PHASE_BITS_DEF;
    localparam int RW = RATE_WIDTH;
    localparam int ONE = 1 << PB;
    localparam int DRAIN_CYCLES = 400;
    localparam int SETTLE_LIMIT = 200000;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 start;
    } in_item_t;

    typedef struct {
        logic signed [SW-1:0] value;
        logic                 last;
    } out_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [SW-1:0] sample_in = '0;
    logic                 buffer_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [SW-1:0] sample_out;
    logic                 run_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic signed [RW-1:0] cfg_data = '0;

    in_item_t  sample_fifo [$];
    out_item_t interp_fifo [$];
    out_item_t head;

    // predictor state
    logic signed [SW-1:0] win [4] = '{default: '0};
    int                   next_pos = ONE;
    int                   fill = 0;
    logic signed [RW-1:0] rate_cfg = '0;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic idle_free = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   n_in = 0;
    int   n_starts = 0;
    int   n_out = 0;
    int   n_bad = 0;
    int   n_rates = 0;

    cubic_lagrange_resampler #(
        .SAMPLE_WIDTH (SW),
        .PHASE_BITS   (PB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .buffer_start (buffer_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .run_last     (run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void resample(input logic signed [SW-1:0] s, input logic start);
        out_item_t res;
        int        r;
        int        adv;
        int        pos;
        int        n;
        longint    t, xmm, xm, xp, w0, w1, w2, w3, inner, outer, v;
        n = 0;
        if (start)
        begin
            win = '{default: '0};
            win[3] = s;
            fill = 1;
            next_pos = 2 * ONE;
            res.value = s;
            res.last = 1'b1;
            interp_fifo.push_back(res);
            return;
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = s;
        if (fill < 4)
            fill++;
        r = int'(rate_cfg);
        if (r < -ONE)
            r = -ONE;
        if (r > ONE - 1)
            r = ONE - 1;
        adv = ONE - r;
        pos = next_pos;
        while (pos < ONE)
        begin
            if (fill >= 4)
            begin
                t = longint'(pos);
                xmm = t - 2 * ONE;
                xm = t - ONE;
                xp = t + ONE;
                w0 = longint'(win[0]);
                w1 = longint'(win[1]);
                w2 = longint'(win[2]);
                w3 = longint'(win[3]);
                inner = ((xm * w1 - t * w2) * (xp * xmm)) / 2;
                outer = ((xp * w3 - xmm * w0) * (t * xm)) / 6;
                v = (inner + outer) >>> (3 * PB);
                if (v > longint'(S_MAX))
                    v = longint'(S_MAX);
                if (v < longint'(S_MIN))
                    v = longint'(S_MIN);
                res.value = v[SW-1:0];
                res.last = 1'b0;
                interp_fifo.push_back(res);
                n++;
            end
            pos += adv;
        end
        next_pos = pos - ONE;
        if (n > 0)
            interp_fifo[interp_fifo.size() - 1].last = 1'b1;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = S_MAX;
            1: v = S_MIN;
            2, 3: v = SW'($urandom_range(0, 200) - 100);
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_item(input logic signed [SW-1:0] s, input logic start);
        in_item_t it;
        it.sample = s;
        it.start = start;
        sample_fifo.push_back(it);
    endtask

    // mostly buffers of random length, some stray samples with a random start bit
    task automatic add_stream(input int count);
        int left;
        int run;
        int i;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                queue_item(pick_sample(), 1'($urandom_range(0, 1)));
                left--;
            end
            else
            begin
                run = $urandom_range(4, 30);
                if (run > left)
                    run = left;
                queue_item(pick_sample(), 1'b1);
                for (i = 1; i < run; i++)
                    queue_item(pick_sample(), 1'b0);
                left -= run;
            end
        end
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        while ((sample_fifo.size() != 0 || in_valid || interp_fifo.size() != 0)
               && guard < SETTLE_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input int r);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r[RW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rate_cfg = r[RW-1:0];
        n_rates++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int r, input int count, input logic calm);
        settle();
        write_rate(r);
        idle_free = calm;
        add_stream(count);
    endtask

    // input side: acceptance and prediction
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            resample(sample_in, buffer_start);
            n_in++;
            if (buffer_start)
                n_starts++;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                void'(sample_fifo.pop_front());
                in_gap = idle_free ? 0 : $urandom_range(0, 8);
            end
            if (!in_valid || in_fire)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_fifo.size() > 0)
                begin
                    in_valid <= 1'b1;
                    sample_in <= sample_fifo[0].sample;
                    buffer_start <= sample_fifo[0].start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                out_gap = idle_free ? 0 : $urandom_range(0, 8);
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            n_out++;
            if (interp_fifo.size() == 0)
            begin
                $display("%0t: unexpected transaction sample_out=%0d run_last=%0b",
                         $time, sample_out, run_last);
                n_bad++;
            end
            else
            begin
                head = interp_fifo.pop_front();
                if (sample_out !== head.value)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, head.value, sample_out);
                    n_bad++;
                end
                if (run_last !== head.last)
                begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, head.last, run_last);
                    n_bad++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_rate(0);
        // no buffer start yet: results begin once four samples fill the window after reset
        queue_item(16'sd1000, 1'b0);
        queue_item(-16'sd1000, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(16'sd5, 1'b0);
        // alternating extremes overshoot and saturate
        queue_item(S_MIN, 1'b1);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MAX, 1'b1);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MIN, 1'b0);
        // back to back buffer starts, then bit patterns
        queue_item(16'sd0, 1'b1);
        queue_item(16'sd0, 1'b1);
        queue_item(16'sh5555, 1'b0);
        queue_item(-16'sh5556, 1'b0);
        queue_item(16'sh5555, 1'b0);
        queue_item(-16'sd1, 1'b0);

        run_phase(-32, 20, 1'b0);
        run_phase(31, 8, 1'b0);
        run_phase(-31, 20, 1'b1);
        run_phase(0, 15, 1'b0);
        repeat (6)
            run_phase($urandom_range(0, 63) - 32, 20, 1'($urandom_range(0, 3) == 0));

        settle();
        if (sample_fifo.size() != 0 || in_valid)
        begin
            $display("%0t: %0d input transactions never accepted", $time, sample_fifo.size());
            n_bad++;
        end
        if (interp_fifo.size() != 0)
        begin
            $display("%0t: %0d expected transactions never arrived", $time, interp_fifo.size());
            n_bad++;
        end
        $display("Covered %0d input transactions (%0d buffer starts), %0d results checked,",
                 n_in, n_starts, n_out);
        $display("across %0d rate settings including both clamp extremes.", n_rates);
        if (n_bad == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
